// ===== design/cses_pkg.sv =====
// Shared types and constants for the CAN signal extract and scale pipeline.
package cses_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned SLEN_W   = 7;
    localparam int unsigned FAC_W    = 32;
    localparam int unsigned OFF_W    = 48;
    localparam int unsigned PROD_W   = 96;
    localparam int unsigned SUM_W    = 97;

    localparam logic [SLEN_W-1:0] SIG_MAX_LEN = 7'd64;

    typedef struct packed {
        logic                    valid_res;
        logic [DATA_W-1:0]       raw;
        logic                    is_signed;
        logic [SLEN_W-1:0]       slen;
        logic signed [FAC_W-1:0] fac;
        logic signed [OFF_W-1:0] off;
    } t_ext;

    typedef struct packed {
        logic                    valid_res;
        logic [DATA_W-1:0]       raw;
        logic [DATA_W-1:0]       sraw;
        logic signed [63:0]      p_hi;
        logic signed [64:0]      p_lo;
        logic signed [OFF_W-1:0] off;
    } t_prod;

endpackage

// ===== design/cses_extract.sv =====
// Stage 1: bounds check and bit gather in Intel or Motorola order.
module cses_extract #(
    parameter int FRAME_BYTES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [63:0]           i_frame_data,
    input  logic [3:0]            i_frame_length,
    input  logic [5:0]            i_start_bit,
    input  logic [6:0]            i_signal_length,
    input  logic                  i_big_endian,
    input  logic                  i_is_signed,
    input  logic signed [31:0]    i_scale_factor,
    input  logic signed [47:0]    i_scale_offset,
    output logic                  o_valid,
    input  logic                  i_ready,
    output cses_pkg::t_ext        o_ext
);
    import cses_pkg::*;

    localparam int          FB_BITS = FRAME_BYTES * 8;
    localparam logic [3:0]  LP_FB   = 4'(FRAME_BYTES);

    logic              r_valid;
    t_ext              r_ext;
    t_ext              n_ext;
    logic [DATA_W-1:0] data_in;
    logic [DATA_W-1:0] data_swap;
    logic [DATA_W-1:0] data_sel;
    logic [DATA_W-1:0] len_mask;
    logic [3:0]        flen;
    logic [6:0]        limit;
    logic [5:0]        pos0;
    logic [7:0]        end_pos;
    logic [6:0]        back;
    logic [5:0]        shamt;
    logic              len_ok;
    logic              ok;

    always_comb begin
        data_in = DATA_W'(i_frame_data[FB_BITS-1:0]);
        for (int b = 0; b < 8; b++) begin
            data_swap[b*8 +: 8] = data_in[(7-b)*8 +: 8];
        end
        flen    = (i_frame_length > LP_FB) ? LP_FB : i_frame_length;
        limit   = {flen, 3'b000};
        pos0    = i_big_endian ? {i_start_bit[5:3], ~i_start_bit[2:0]} : i_start_bit;
        end_pos = 8'(pos0) + 8'(i_signal_length);
        len_ok  = (i_signal_length != '0) && (i_signal_length <= SIG_MAX_LEN);
        ok      = len_ok && (flen != '0) && (end_pos <= 8'(limit));
        back    = 7'd64 - end_pos[6:0];
        shamt   = i_big_endian ? back[5:0] : pos0;
        data_sel = i_big_endian ? data_swap : data_in;
        len_mask = ~({DATA_W{1'b1}} << i_signal_length);

        n_ext.valid_res = ok;
        n_ext.raw       = ok ? ((data_sel >> shamt) & len_mask) : '0;
        n_ext.is_signed = i_is_signed;
        n_ext.slen      = i_signal_length;
        n_ext.fac       = i_scale_factor;
        n_ext.off       = ok ? i_scale_offset : '0;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ext <= n_ext;
        end
    end

    assign o_valid = r_valid;
    assign o_ext   = r_ext;

endmodule

// ===== design/cses_mult.sv =====
// Stages 2-3: sign extension, then two partial products of the 32-bit halves of raw times factor.
module cses_mult (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  cses_pkg::t_ext  i_ext,
    output logic            o_valid,
    input  logic            i_ready,
    output cses_pkg::t_prod o_prod
);
    import cses_pkg::*;

    logic                    r_v1;
    logic                    r_vr1;
    logic [DATA_W-1:0]       r_raw1;
    logic [DATA_W-1:0]       r_sraw1;
    logic signed [FAC_W-1:0] r_fac1;
    logic signed [OFF_W-1:0] r_off1;
    logic [DATA_W-1:0]       n_sraw1;
    logic [5:0]              msb_idx;
    logic                    rdy1;

    logic                    r_v2;
    t_prod                   r_prod;
    t_prod                   n_prod;
    logic signed [31:0]      hi_s;
    logic signed [32:0]      lo_s;

    always_comb begin
        msb_idx = 6'(i_ext.slen - 7'd1);
        if (i_ext.is_signed && (i_ext.slen < SIG_MAX_LEN) && i_ext.raw[msb_idx]) begin
            n_sraw1 = i_ext.raw | ({DATA_W{1'b1}} << i_ext.slen);
        end else begin
            n_sraw1 = i_ext.raw;
        end
    end

    assign o_ready = !r_v1 || rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vr1   <= i_ext.valid_res;
            r_raw1  <= i_ext.raw;
            r_sraw1 <= n_sraw1;
            r_fac1  <= i_ext.fac;
            r_off1  <= i_ext.off;
        end
    end

    always_comb begin
        hi_s             = $signed(r_sraw1[63:32]);
        lo_s             = $signed({1'b0, r_sraw1[31:0]});
        n_prod.valid_res = r_vr1;
        n_prod.raw       = r_raw1;
        n_prod.sraw      = r_sraw1;
        n_prod.p_hi      = hi_s * r_fac1;
        n_prod.p_lo      = lo_s * r_fac1;
        n_prod.off       = r_off1;
    end

    assign rdy1 = !r_v2 || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy1) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && r_v1) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;

endmodule

// ===== design/cses_accum.sv =====
// Stages 4-5: partial product sum, offset add and 64-bit saturation.
module cses_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cses_pkg::t_prod    i_prod,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_valid_res,
    output logic [63:0]        o_raw_bits,
    output logic signed [63:0] o_signed_raw,
    output logic signed [63:0] o_scaled_value,
    output logic               o_overflow
);
    import cses_pkg::*;

    logic                    r_v1;
    logic                    r_vr1;
    logic [DATA_W-1:0]       r_raw1;
    logic [DATA_W-1:0]       r_sraw1;
    logic [PROD_W-1:0]       r_prod1;
    logic signed [OFF_W-1:0] r_off1;
    logic [PROD_W-1:0]       n_prod1;
    logic [63:0]             upper;
    logic                    rdy1;

    logic                    r_v2;
    logic                    r_vr2;
    logic [DATA_W-1:0]       r_raw2;
    logic [DATA_W-1:0]       r_sraw2;
    logic [63:0]             r_scaled2;
    logic                    r_ovf2;
    logic [SUM_W-1:0]        sum;
    logic [63:0]             n_scaled2;
    logic                    n_ovf2;

    always_comb begin
        upper   = i_prod.p_hi + {{31{i_prod.p_lo[64]}}, i_prod.p_lo[64:32]};
        n_prod1 = {upper, i_prod.p_lo[31:0]};
    end

    assign o_ready = !r_v1 || rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (o_ready) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_vr1   <= i_prod.valid_res;
            r_raw1  <= i_prod.raw;
            r_sraw1 <= i_prod.sraw;
            r_prod1 <= n_prod1;
            r_off1  <= i_prod.off;
        end
    end

    always_comb begin
        sum = {r_prod1[PROD_W-1], r_prod1}
            + {{(SUM_W-OFF_W){r_off1[OFF_W-1]}}, r_off1};
        if ((&sum[SUM_W-1:63]) || !(|sum[SUM_W-1:63])) begin
            n_scaled2 = sum[63:0];
            n_ovf2    = 1'b0;
        end else if (sum[SUM_W-1]) begin
            n_scaled2 = {1'b1, 63'd0};
            n_ovf2    = 1'b1;
        end else begin
            n_scaled2 = {1'b0, {63{1'b1}}};
            n_ovf2    = 1'b1;
        end
    end

    assign rdy1 = !r_v2 || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy1) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && r_v1) begin
            r_vr2     <= r_vr1;
            r_raw2    <= r_raw1;
            r_sraw2   <= r_sraw1;
            r_scaled2 <= n_scaled2;
            r_ovf2    <= n_ovf2;
        end
    end

    assign o_valid        = r_v2;
    assign o_valid_res    = r_vr2;
    assign o_raw_bits     = r_raw2;
    assign o_signed_raw   = $signed(r_sraw2);
    assign o_scaled_value = $signed(r_scaled2);
    assign o_overflow     = r_ovf2;

endmodule

// ===== design/can_signal_extract_scale.sv =====
// Top level: CAN signal extract and fixed-point scale pipeline.
//
// Input channel (i_valid / o_ready) carries one payload of up to eight bytes
// plus one signal descriptor per beat. Output channel (o_valid / i_ready)
// returns exactly one result beat per input beat, in order.
//
// Five register stages: gather, sign extension, partial products,
// product sum, offset add with saturation. o_valid rises once a beat has
// passed through all five registers; one beat per cycle is sustained while
// the receiver keeps i_ready high.
//
// Each stage has its own valid bit and holds its contents while the stage
// after it is full and stalled, so empty slots are squeezed out and o_ready
// drops only once every stage holds a beat. Nothing is dropped or repeated.
//
// Reset clears all stage valid bits; the pipeline is empty and ready on the
// first cycle after reset.
module can_signal_extract_scale #(
    parameter int FRAME_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [63:0]        i_frame_data,
    input  logic [3:0]         i_frame_length,
    input  logic [5:0]         i_start_bit,
    input  logic [6:0]         i_signal_length,
    input  logic               i_big_endian,
    input  logic               i_is_signed,
    input  logic signed [31:0] i_scale_factor,
    input  logic signed [47:0] i_scale_offset,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_valid_res,
    output logic [63:0]        o_raw_bits,
    output logic signed [63:0] o_signed_raw,
    output logic signed [63:0] o_scaled_value,
    output logic               o_overflow
);
    import cses_pkg::*;

    logic  ext_valid;
    logic  ext_ready;
    t_ext  ext;
    logic  prod_valid;
    logic  prod_ready;
    t_prod prod;

    cses_extract #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_extract (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_frame_data    (i_frame_data),
        .i_frame_length  (i_frame_length),
        .i_start_bit     (i_start_bit),
        .i_signal_length (i_signal_length),
        .i_big_endian    (i_big_endian),
        .i_is_signed     (i_is_signed),
        .i_scale_factor  (i_scale_factor),
        .i_scale_offset  (i_scale_offset),
        .o_valid         (ext_valid),
        .i_ready         (ext_ready),
        .o_ext           (ext)
    );

    cses_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ext_valid),
        .o_ready (ext_ready),
        .i_ext   (ext),
        .o_valid (prod_valid),
        .i_ready (prod_ready),
        .o_prod  (prod)
    );

    cses_accum u_accum (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (prod_valid),
        .o_ready        (prod_ready),
        .i_prod         (prod),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_valid_res    (o_valid_res),
        .o_raw_bits     (o_raw_bits),
        .o_signed_raw   (o_signed_raw),
        .o_scaled_value (o_scaled_value),
        .o_overflow     (o_overflow)
    );

endmodule

// ===== test/can_signal_extract_scale_tb.sv =====
// Testbench for can_signal_extract_scale: directed table plus random frames, checked per beat.
module can_signal_extract_scale_tb;
    import cses_pkg::*;

    localparam int FRAME_MAX   = 8;
    localparam int RAND_ITEMS  = 1350;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 12;
    localparam logic signed [127:0] SAT_HI = 128'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [127:0] SAT_LO = -128'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [DATA_W-1:0]       frame_data;
        logic [3:0]              frame_length;
        logic [5:0]              start_bit;
        logic [SLEN_W-1:0]       signal_length;
        logic                    big_endian;
        logic                    is_signed;
        logic signed [FAC_W-1:0] scale_factor;
        logic signed [OFF_W-1:0] scale_offset;
    } t_sig_req;

    typedef struct packed {
        logic              valid_res;
        logic [DATA_W-1:0] raw_bits;
        logic [DATA_W-1:0] signed_raw;
        logic [DATA_W-1:0] scaled_value;
        logic              overflow;
    } t_sig_result;

    typedef struct {
        t_sig_req    req;
        bit          typed;
        t_sig_result res;
    } t_dir_row;

    typedef enum int {RDY_OPEN, RDY_BUSY, RDY_CHOKED, RDY_HOLD} t_rdy_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [63:0]        i_frame_data = '0;
    logic [3:0]         i_frame_length = '0;
    logic [5:0]         i_start_bit = '0;
    logic [6:0]         i_signal_length = '0;
    logic               i_big_endian = 1'b0;
    logic               i_is_signed = 1'b0;
    logic signed [31:0] i_scale_factor = '0;
    logic signed [47:0] i_scale_offset = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_valid_res;
    logic [63:0]        o_raw_bits;
    logic signed [63:0] o_signed_raw;
    logic signed [63:0] o_scaled_value;
    logic               o_overflow;

    t_sig_result pending_results[$];
    t_dir_row    dir_rows[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          rdy_left = 0;
    t_rdy_mode   rdy_mode = RDY_OPEN;
    t_sig_result want;

    can_signal_extract_scale dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_frame_data   (i_frame_data),
        .i_frame_length (i_frame_length),
        .i_start_bit    (i_start_bit),
        .i_signal_length(i_signal_length),
        .i_big_endian   (i_big_endian),
        .i_is_signed    (i_is_signed),
        .i_scale_factor (i_scale_factor),
        .i_scale_offset (i_scale_offset),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_valid_res    (o_valid_res),
        .o_raw_bits     (o_raw_bits),
        .o_signed_raw   (o_signed_raw),
        .o_scaled_value (o_scaled_value),
        .o_overflow     (o_overflow)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_sig_result decode_signal(t_sig_req r);
        t_sig_result res;
        int flen, pos, bytei, k;
        logic [63:0] raw, sraw;
        logic signed [127:0] a_w, f_w, o_w, acc;
        bit ok;
        res = '0;
        raw = '0;
        flen = (r.frame_length > FRAME_MAX) ? FRAME_MAX : r.frame_length;
        pos = r.start_bit;
        ok = r.signal_length != 0 && r.signal_length <= SIG_MAX_LEN && flen != 0;
        for (k = 0; ok && k < r.signal_length; k++) begin
            bytei = pos / 8;
            if (bytei >= flen) begin
                ok = 1'b0;
            end else if (r.big_endian) begin
                raw = {raw[62:0], r.frame_data[pos]};
                pos = (pos % 8 == 0) ? bytei * 8 + 15 : pos - 1;
            end else begin
                raw[k] = r.frame_data[pos];
                pos++;
            end
        end
        if (!ok)
            return res;
        sraw = raw;
        if (r.is_signed && r.signal_length < SIG_MAX_LEN && raw[r.signal_length - 1])
            sraw = raw | ({64{1'b1}} << r.signal_length);
        a_w = $signed(sraw);
        f_w = $signed(r.scale_factor);
        o_w = $signed(r.scale_offset);
        acc = a_w * f_w + o_w;
        res.valid_res  = 1'b1;
        res.raw_bits   = raw;
        res.signed_raw = sraw;
        if (acc > SAT_HI) begin
            res.scaled_value = SAT_HI[63:0];
            res.overflow     = 1'b1;
        end else if (acc < SAT_LO) begin
            res.scaled_value = SAT_LO[63:0];
            res.overflow     = 1'b1;
        end else begin
            res.scaled_value = acc[63:0];
        end
        return res;
    endfunction

    function automatic bit fits_frame(int sb, int sl, int fl, bit moto);
        if (moto)
            return (sb / 8 < fl) && ((sb % 8) + 1 + 8 * (fl - 1 - sb / 8) >= sl);
        return sb + sl <= fl * 8;
    endfunction

    function automatic t_sig_req random_req();
        t_sig_req r;
        int fl, sl, sb;
        r.frame_data = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: r.frame_data = '1;
            1: r.frame_data = '0;
            default: ;
        endcase
        r.big_endian = 1'($urandom_range(0, 1));
        r.is_signed  = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: r.scale_factor = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            1: r.scale_factor = $signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000;
            2: r.scale_factor = 32'sh0001_0000;
            3: r.scale_factor = '0;
            default: r.scale_factor = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0: r.scale_offset = $urandom_range(0, 1) ? 48'sh7FFF_FFFF_FFFF
                                                     : 48'sh8000_0000_0000;
            1: r.scale_offset = $signed({16'h0, $urandom_range(0, 32'h3_FFFF)}) - 48'sh2_0000;
            2: r.scale_offset = '0;
            default: r.scale_offset = 48'({$urandom, $urandom});
        endcase
        if ($urandom_range(0, 99) < 15) begin
            r.frame_length  = 4'($urandom_range(0, 15));
            r.start_bit     = 6'($urandom_range(0, 63));
            r.signal_length = 7'($urandom_range(0, 127));
        end else begin
            fl = $urandom_range(1, 8);
            sl = $urandom_range(0, 1) ? $urandom_range(1, (fl * 8 < 16) ? fl * 8 : 16)
                                      : $urandom_range(1, fl * 8);
            do
                sb = $urandom_range(0, fl * 8 - 1);
            while (!fits_frame(sb, sl, fl, r.big_endian));
            r.frame_length  = ($urandom_range(0, 19) == 0 && fl == 8) ? 4'd15 : 4'(fl);
            r.start_bit     = 6'(sb);
            r.signal_length = 7'(sl);
        end
        return r;
    endfunction

    task automatic add_row(input logic [63:0] d, input logic [3:0] fl, input logic [5:0] sb,
                           input logic [6:0] sl, input logic be, input logic sg,
                           input logic [31:0] fa, input logic [47:0] of,
                           input bit typed, input t_sig_result res);
        t_dir_row row;
        row.req   = '{d, fl, sb, sl, be, sg, fa, of};
        row.typed = typed;
        row.res   = res;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_req(input t_sig_req r, input bit typed, input t_sig_result res);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_frame_data    <= r.frame_data;
        i_frame_length  <= r.frame_length;
        i_start_bit     <= r.start_bit;
        i_signal_length <= r.signal_length;
        i_big_endian    <= r.big_endian;
        i_is_signed     <= r.is_signed;
        i_scale_factor  <= r.scale_factor;
        i_scale_offset  <= r.scale_offset;
        i_valid         <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_ready);
        pending_results.insert(pending_results.size(), typed ? res : decode_signal(r));
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected %h got %h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(negedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode = t_rdy_mode'($urandom_range(0, 3));
            rdy_left = (rdy_mode == RDY_HOLD) ? $urandom_range(3, 40) : $urandom_range(16, 300);
        end
        rdy_left--;
        case (rdy_mode)
            RDY_OPEN:   i_ready <= 1'b1;
            RDY_BUSY:   i_ready <= ($urandom_range(0, 9) < 7);
            RDY_CHOKED: i_ready <= ($urandom_range(0, 9) < 2);
            default:    i_ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing pending, raw %h", $time, o_raw_bits);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("valid_res", 64'(want.valid_res), 64'(o_valid_res));
                check_field("raw_bits", want.raw_bits, o_raw_bits);
                check_field("signed_raw", want.signed_raw, o_signed_raw);
                check_field("scaled_value", want.scaled_value, o_scaled_value);
                check_field("overflow", 64'(want.overflow), 64'(o_overflow));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int n;
        // bad length, empty frame, bits past the frame: all fields zero
        add_row({$urandom, $urandom}, 4'd8, 6'd0, 7'd0, 1'b0, 1'b0, 32'h1_0000, '0, 1'b1, '0);
        add_row({$urandom, $urandom}, 4'd0, 6'd0, 7'd8, 1'b0, 1'b1, 32'h1_0000, '0, 1'b1, '0);
        add_row({$urandom, $urandom}, 4'd8, 6'd0, 7'd65, 1'b0, 1'b0, 32'h1_0000, '0, 1'b1, '0);
        add_row({$urandom, $urandom}, 4'd8, 6'd7, 7'd127, 1'b1, 1'b0, 32'h1_0000, '0, 1'b1, '0);
        add_row({$urandom, $urandom}, 4'd1, 6'd4, 7'd5, 1'b0, 1'b0, 32'h1_0000, '0, 1'b1, '0);
        add_row({$urandom, $urandom}, 4'd2, 6'd8, 7'd2, 1'b1, 1'b0, 32'h1_0000, '0, 1'b1, '0);
        add_row({$urandom, $urandom}, 4'd8, 6'd63, 7'd9, 1'b1, 1'b1, 32'h1_0000, '0, 1'b1, '0);
        add_row({$urandom, $urandom}, 4'd8, 6'd56, 7'd9, 1'b0, 1'b1, 32'h1_0000, '0, 1'b1, '0);
        add_row({$urandom, $urandom}, 4'd15, 6'd60, 7'd5, 1'b0, 1'b0, 32'h1_0000, '0, 1'b1, '0);
        // full frame, oversized length, all ones reads as -1 at bit 63
        add_row('1, 4'd15, 6'd0, 7'd64, 1'b0, 1'b0, 32'h1_0000, '0, 1'b1,
                t_sig_result'({1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                               64'hFFFF_FFFF_FFFF_0000, 1'b0}));
        add_row(64'h7FFF_FFFF_FFFF_FFFF, 4'd8, 6'd0, 7'd64, 1'b0, 1'b1, 32'h7FFF_FFFF,
                48'h7FFF_FFFF_FFFF, 1'b1,
                t_sig_result'({1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                               64'h7FFF_FFFF_FFFF_FFFF, 1'b1}));
        add_row(64'h8000_0000_0000_0000, 4'd8, 6'd0, 7'd64, 1'b0, 1'b1, 32'h7FFF_FFFF, '0,
                1'b1,
                t_sig_result'({1'b1, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
                               64'h8000_0000_0000_0000, 1'b1}));
        add_row({$urandom, $urandom}, 4'd8, 6'd7, 7'd64, 1'b1, 1'b1, 32'h8000_0000,
                48'h8000_0000_0000, 1'b0, '0);
        add_row(64'h0000_0000_0000_0F80, 4'd8, 6'd7, 7'd12, 1'b1, 1'b1, 32'h1_0000,
                48'h0_8000, 1'b0, '0);
        add_row({$urandom, $urandom}, 4'd8, 6'd0, 7'd16, 1'b1, 1'b0, 32'hFFFF_8000, '0,
                1'b0, '0);
        add_row(64'h80, 4'd1, 6'd0, 7'd8, 1'b0, 1'b1, 32'h1_0000, '0, 1'b0, '0);
        add_row(64'h8000_0000_0000_0000, 4'd8, 6'd63, 7'd1, 1'b0, 1'b1, 32'h7FFF_FFFF,
                48'h8000_0000_0000, 1'b0, '0);
        add_row({$urandom, $urandom}, 4'd8, 6'd63, 7'd8, 1'b1, 1'b1, 32'h0, 48'hFFFF_FFFF_0000,
                1'b0, '0);
        add_row({$urandom, $urandom}, 4'd9, 6'd23, 7'd40, 1'b1, 1'b0, 32'h0002_8000,
                48'h0000_1234_5678, 1'b0, '0);
        add_row(64'h00FF_FFFF_FFFF_FFFF, 4'd7, 6'd0, 7'd56, 1'b0, 1'b0, 32'h7FFF_FFFF,
                48'h7FFF_FFFF_FFFF, 1'b0, '0);
        add_row(64'h00FF_FFFF_FFFF_FFFF, 4'd7, 6'd0, 7'd56, 1'b0, 1'b0, 32'h8000_0000,
                48'h8000_0000_0000, 1'b0, '0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[k])
            send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
        for (n = 0; n < RAND_ITEMS; n++)
            send_req(random_req(), 1'b0, '0);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/cses_pkg.sv
design/cses_extract.sv
design/cses_mult.sv
design/cses_accum.sv
design/can_signal_extract_scale.sv
test/can_signal_extract_scale_tb.sv
